/* rtl/plm_pkg.sv */
// Shared types and constants for the block peak level meter.
`timescale 1ns / 1ps

package plm_pkg;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } plm_op_t;

    localparam logic [1:0] CFG_SAMPLE_IS_16BIT  = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_IS_SIGNED = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN       = 2'd2;

    localparam logic [15:0] FULL_8U  = 16'd255;
    localparam logic [15:0] FULL_8S  = 16'd127;
    localparam logic [15:0] FULL_16U = 16'd65535;
    localparam logic [15:0] FULL_16S = 16'd32767;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // One event handed from the front to the back: a block end or a clear.
    typedef struct packed
    {
        logic        is_clear;
        logic [15:0] peak;
        logic        fmt16;
        logic        fmt_signed;
    } plm_event_t;

endpackage

/* rtl/block_peak_level_meter.sv */
// Top level of the block peak level meter.
`timescale 1ns / 1ps
//
// Sample requests enter on the s_ channel: s_tdata is the raw sample word,
// s_tuser the operation (0 sample, 1 clear history and hold), s_tlast marks
// the last word of a block. A block end or a clear gives one result request
// on the m_ channel; other samples give none.
// Format registers are written over the cfg channel (index 0 width, 1 sign,
// 2 byte order; only data bit 0 counts), always ready.
// Throughput: one request per cycle sustained while the event queue is not
// full. The front tracks the block peak; a four-entry event queue feeds the
// back, which scales the level, updates the history ring RAM and running sum,
// multiplies the sum by a reciprocal of the depth and updates the hold, one
// stage each. A block end or clear is registered into the event queue and then
// passes through the level, ring, product and output registers in order.
// Reset clears the block peak, last level, running sum, ring index and hold,
// and restores 16-bit signed little-endian format; the ring needs no clearing
// pass, as a fill count masks entries not written since the last clear.
// When the receiver stalls, the result is held, the back stops, and the front
// keeps accepting samples until the event queue is full.

module block_peak_level_meter #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_word
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // block_level, average_level, held_maximum
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    import plm_pkg::*;

    logic       ev_valid;
    plm_event_t ev_data;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    plm_event_t q_head;

    plm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .ev_valid  (ev_valid),
        .ev_data   (ev_data)
    );

    plm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_valid),
        .push_data (ev_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    plm_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/plm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module plm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/plm_queue.sv */
// Short event queue between the front and back parts.
`timescale 1ns / 1ps

module plm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  plm_pkg::plm_event_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output plm_pkg::plm_event_t head
);
    import plm_pkg::*;

    plm_event_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic [QUEUE_CNT_W-1:0]  count_next;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("event queue overflow");
`endif

endmodule

/* rtl/plm_front.sv */
// Front part: configuration, sample decoding and block peak tracking.
`timescale 1ns / 1ps

module plm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic                cfg_data,
    input  logic                q_full,
    output logic                ev_valid,
    output plm_pkg::plm_event_t ev_data
);
    import plm_pkg::*;

    logic        fmt16_reg;
    logic        fmt_signed_reg;
    logic        big_endian_reg;
    logic [15:0] peak_reg;
    logic [15:0] peak_next;

    logic        accept;
    logic        is_clear;
    logic [15:0] word;
    logic [15:0] mag;
    logic [7:0]  byte_neg;
    logic [15:0] word_neg;
    logic [15:0] peak_max;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign is_clear  = (s_tuser == OP_CLEAR);

    always_comb
    begin
        word     = big_endian_reg ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;
        byte_neg = ~s_tdata[7:0] + 8'd1;
        word_neg = ~word + 16'd1;
        if (!fmt16_reg)
        begin
            mag = (fmt_signed_reg && s_tdata[7]) ? {8'd0, byte_neg} : {8'd0, s_tdata[7:0]};
        end
        else
        begin
            mag = (fmt_signed_reg && word[15]) ? word_neg : word;
        end
        peak_max = (mag > peak_reg) ? mag : peak_reg;
    end

    always_comb
    begin
        peak_next           = peak_reg;
        ev_valid            = 1'b0;
        ev_data.is_clear    = is_clear;
        ev_data.peak        = peak_max;
        ev_data.fmt16       = fmt16_reg;
        ev_data.fmt_signed  = fmt_signed_reg;
        if (accept)
        begin
            if (is_clear)
            begin
                ev_valid = 1'b1;
            end
            else if (s_tlast)
            begin
                ev_valid  = 1'b1;
                peak_next = '0;
            end
            else
            begin
                peak_next = peak_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt16_reg      <= 1'b1;
            fmt_signed_reg <= 1'b1;
            big_endian_reg <= 1'b0;
            peak_reg       <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_IS_16BIT:  fmt16_reg      <= cfg_data;
                    CFG_SAMPLE_IS_SIGNED: fmt_signed_reg <= cfg_data;
                    CFG_BIG_ENDIAN:       big_endian_reg <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_peak_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_clear && s_tlast |=> peak_reg == '0)
        else $error("block peak not restarted at block end");
    a_clear_keeps_peak: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_clear |=> $stable(peak_reg))
        else $error("clear request disturbed block peak");
`endif

endmodule

/* rtl/plm_back.sv */
// Back part: level scaling, history ring, moving average and hold.
`timescale 1ns / 1ps

module plm_back #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  plm_pkg::plm_event_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata
);
    import plm_pkg::*;

    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = 16 + IDX_W;
    localparam int SHIFT   = SUM_W + IDX_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic en;

    // stage 1: level
    logic        s1_valid_reg;
    logic        s1_clear_reg;
    logic [15:0] s1_level_reg;
    logic [15:0] last_level_reg;
    logic [15:0] clamp;
    logic [6:0]  p7;
    logic [8:0]  tri_p;
    logic [1:0]  frac;
    logic [15:0] level_calc;

    // stage 2: ring update
    logic              s2_valid_reg;
    logic              s2_clear_reg;
    logic [15:0]       s2_level_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_inc;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              ring_full;
    logic [15:0]       ram_q;
    logic [15:0]       old_sel;
    logic [SUM_W-1:0]  sum_base;
    logic [IDX_W-1:0]  ram_raddr;
    logic              adv2;

    // stage 3: reciprocal product
    logic              s3_valid_reg;
    logic              s3_clear_reg;
    logic [15:0]       s3_level_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [15:0]       avg;

    // output
    logic        out_valid_reg;
    logic [15:0] out_level_reg;
    logic [15:0] out_avg_reg;
    logic [15:0] hold_reg;

    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && !q_empty;

    // clamp to full scale and scale to a 16-bit fraction
    always_comb
    begin
        clamp      = q_head.peak;
        p7         = '0;
        tri_p      = '0;
        frac       = '0;
        level_calc = '0;
        unique case ({q_head.fmt16, q_head.fmt_signed})
            2'b00:
            begin
                clamp      = (q_head.peak > FULL_8U) ? FULL_8U : q_head.peak;
                level_calc = {clamp[7:0], clamp[7:0]};
            end
            2'b01:
            begin
                clamp = (q_head.peak > FULL_8S) ? FULL_8S : q_head.peak;
                p7    = clamp[6:0];
                tri_p = {1'b0, p7, 1'b0} + {2'b00, p7} + 9'd63;
                if (tri_p >= 9'd381)
                begin
                    frac = 2'd3;
                end
                else if (tri_p >= 9'd254)
                begin
                    frac = 2'd2;
                end
                else if (tri_p >= 9'd127)
                begin
                    frac = 2'd1;
                end
                level_calc = {p7, 9'd0} + {7'd0, p7, 2'd0} + {14'd0, frac};
            end
            2'b10:
            begin
                level_calc = q_head.peak;
            end
            2'b11:
            begin
                clamp      = (q_head.peak > FULL_16S) ? FULL_16S : q_head.peak;
                level_calc = {clamp[14:0], clamp[14]};
            end
            default:
            begin
                level_calc = '0;
            end
        endcase
    end

    // ring bookkeeping; unwritten entries since the last clear read as zero
    assign adv2      = en && s1_valid_reg;
    assign idx_inc   = (idx_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    assign ram_raddr = adv2 ? idx_inc : idx_reg;
    assign ring_full = (fill_reg == FILL_W'(HISTORY_DEPTH));

    always_comb
    begin
        sum_base  = s1_clear_reg ? '0 : sum_reg;
        old_sel   = (!s1_clear_reg && ring_full) ? ram_q : 16'd0;
        sum_next  = sum_base - SUM_W'(old_sel) + SUM_W'(s1_level_reg);
        if (s1_clear_reg)
        begin
            fill_next = FILL_W'(1);
        end
        else if (ring_full)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    plm_ram #(
        .WIDTH (16),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (adv2),
        .waddr (idx_reg),
        .wdata (s1_level_reg),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign avg = prod_reg[SHIFT +: 16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_clear_reg  <= q_head.is_clear;
            s1_level_reg  <= q_head.is_clear ? last_level_reg : level_calc;
            s2_clear_reg  <= s1_clear_reg;
            s2_level_reg  <= s1_level_reg;
            s3_clear_reg  <= s2_clear_reg;
            s3_level_reg  <= s2_level_reg;
            prod_reg      <= PROD_W'({{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP});
            out_level_reg <= s3_level_reg;
            out_avg_reg   <= avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_level_reg <= '0;
            sum_reg        <= '0;
            idx_reg        <= '0;
            fill_reg       <= '0;
            hold_reg       <= '0;
        end
        else if (en)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (!q_empty && !q_head.is_clear)
            begin
                last_level_reg <= level_calc;
            end
            if (s1_valid_reg)
            begin
                sum_reg  <= sum_next;
                idx_reg  <= idx_inc;
                fill_reg <= fill_next;
            end
            if (s3_valid_reg && (s3_clear_reg || avg > hold_reg))
            begin
                hold_reg <= avg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {hold_reg, out_avg_reg, out_level_reg};

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("ring fill count out of range");
    a_hold_covers_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> hold_reg >= out_avg_reg)
        else $error("held maximum below average");
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        adv2 |=> fill_reg != '0)
        else $error("ring push left fill count at zero");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sum_reg) && $stable(idx_reg))
        else $error("ring state moved during output stall");
`endif

endmodule
